FILE: design/crsh_pkg.sv
// ----------------------------------------------------------------------------
// crsh_pkg
// Types and fixed widths shared by the closest ray-sphere hit unit.
// ----------------------------------------------------------------------------
package crsh_pkg;

    localparam int POS_W  = 32;     // Q16.16 positions and directions
    localparam int RAD_W  = 31;     // sphere radius
    localparam int TAG_W  = 8;      // material tag
    localparam int SLOT_W = 4;      // table slot field
    localparam int CNT_W  = 5;      // sphere_count register
    localparam int NRM_W  = 18;     // normal output components
    localparam int VEC_W  = 38;     // internal vectors, distances, b
    localparam int OC_W   = 33;     // center minus origin
    localparam int SH_W   = VEC_W + 2;  // product shifted back by the fraction
    localparam int H_W    = SH_W + 1;   // perpendicular offset
    localparam int PT_W   = SH_W + 1;   // hit point before saturation
    localparam int SQ_W   = 62;     // square of a 31-bit magnitude
    localparam int ACC_W  = 64;     // sum of three squares
    localparam int ROOT_W = 32;     // floor root of a 64-bit value
    localparam int REM_W  = 34;     // root remainder
    localparam int IT_W   = 5;      // iteration counter
    localparam int K_W    = 3;      // step counter inside a state

    localparam logic [IT_W-1:0] SQRT_LAST = 5'd31;

    localparam logic signed [31:0] NRM_MAX = 32'sd131071;
    localparam logic signed [31:0] NRM_MIN = -32'sd131072;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_TRACE = 1'b1;

    typedef struct packed {
        logic signed [POS_W-1:0] cx;
        logic signed [POS_W-1:0] cy;
        logic signed [POS_W-1:0] cz;
        logic        [RAD_W-1:0] rad;
        logic        [TAG_W-1:0] tag;
    } sphere_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_NORM_INIT,
        ST_NORM_SHIFT,
        ST_NORM_SQ,
        ST_NORM_SQRT,
        ST_NORM_DIV,
        ST_NORM_END,
        ST_RD,
        ST_OC,
        ST_DOT,
        ST_B,
        ST_H,
        ST_SQ,
        ST_CMP,
        ST_TSQRT,
        ST_T,
        ST_FRD,
        ST_FC,
        ST_P,
        ST_ND,
        ST_FIN
    } state_t;

endpackage

FILE: design/closest_ray_sphere_hit_top.sv
// ----------------------------------------------------------------------------
// closest_ray_sphere_hit_top
// Sphere table plus a sequenced closest-hit tracer in fixed point.
// ----------------------------------------------------------------------------
// A load item writes one sphere table entry. A trace item runs through one
// shared datapath: the direction is normalised (up to 30 alignment shifts,
// 4 squaring steps, the bit-serial square root of 32 result bits and three
// restoring divides of FRAC_BITS+1 quotient bits each), then every tested
// sphere is checked in turn; a sphere rejected on its offset or failing the
// discriminant skips the square root. A hit adds a reread of the best sphere,
// the hit point, and a second normalisation of the normal with a facing test.
// The square-root unit dominates the work for each tested sphere. The result
// sits in an output register, so the next item is taken while it waits.
// ----------------------------------------------------------------------------
module closest_ray_sphere_hit_top #(
    parameter int MAX_SPHERES = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [crsh_pkg::CNT_W-1:0]        cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_req_type,
    input  logic [crsh_pkg::SLOT_W-1:0]       s_slot,
    input  logic signed [crsh_pkg::POS_W-1:0] s_pos_x,
    input  logic signed [crsh_pkg::POS_W-1:0] s_pos_y,
    input  logic signed [crsh_pkg::POS_W-1:0] s_pos_z,
    input  logic signed [crsh_pkg::POS_W-1:0] s_dir_x,
    input  logic signed [crsh_pkg::POS_W-1:0] s_dir_y,
    input  logic signed [crsh_pkg::POS_W-1:0] s_dir_z,
    input  logic [crsh_pkg::RAD_W-1:0]        s_sphere_radius,
    input  logic [crsh_pkg::TAG_W-1:0]        s_material_tag,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_hit,
    output logic [crsh_pkg::RAD_W-1:0]        m_distance,
    output logic signed [crsh_pkg::POS_W-1:0] m_point_x,
    output logic signed [crsh_pkg::POS_W-1:0] m_point_y,
    output logic signed [crsh_pkg::POS_W-1:0] m_point_z,
    output logic signed [crsh_pkg::NRM_W-1:0] m_normal_x,
    output logic signed [crsh_pkg::NRM_W-1:0] m_normal_y,
    output logic signed [crsh_pkg::NRM_W-1:0] m_normal_z,
    output logic [crsh_pkg::TAG_W-1:0]        m_hit_tag
);
    import crsh_pkg::*;

    localparam int AW    = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
    localparam int CW    = $clog2(MAX_SPHERES + 1);
    localparam int CMP_W = (CW > CNT_W) ? CW : CNT_W;
    localparam int U_W   = FRAC_BITS + 2;
    localparam int Q_W   = FRAC_BITS + 1;
    localparam int P_W   = U_W + VEC_W;
    localparam int DOT_W = P_W + 2;
    localparam logic [IT_W-1:0]  DIV_LAST  = IT_W'(Q_W - 1);
    localparam logic [CMP_W-1:0] MAX_COUNT = CMP_W'(MAX_SPHERES);

    // ------------------------------------------------------------------
    // Sphere table
    // ------------------------------------------------------------------
    sphere_t         mem [MAX_SPHERES];
    sphere_t         rd_reg;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    sphere_t         mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_reg <= mem[mem_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t state_reg, state_next;
    logic [CNT_W-1:0] sphere_count_reg;

    logic signed [POS_W-1:0] org_reg [3], org_next [3];
    logic signed [U_W-1:0]   u_reg [3], u_next [3];
    logic signed [U_W-1:0]   nrm_reg [3], nrm_next [3];
    logic signed [VEC_W-1:0] vec_reg [3], vec_next [3];
    logic [VEC_W-1:0]        na_reg [3], na_next [3];
    logic                    sgn_reg [3], sgn_next [3];
    logic [VEC_W-1:0]        nm_reg, nm_next;
    logic                    norm_mode_reg, norm_mode_next;
    logic                    norm_ok_reg, norm_ok_next;

    logic signed [P_W-1:0]   prod_a_reg, prod_a_next;
    logic [SQ_W-1:0]         prod_s_reg, prod_s_next;
    logic signed [DOT_W-1:0] dot_reg, dot_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic [SQ_W-1:0]         r2_reg, r2_next;

    logic [ACC_W-1:0]        sq_x_reg, sq_x_next;
    logic [REM_W-1:0]        sq_rem_reg, sq_rem_next;
    logic [ROOT_W-1:0]       sq_root_reg, sq_root_next;
    logic [ROOT_W:0]         dv_rem_reg, dv_rem_next;
    logic [Q_W-1:0]          dv_q_reg, dv_q_next;

    logic signed [OC_W-1:0]  oc_reg [3], oc_next [3];
    logic [RAD_W-1:0]        rad_reg, rad_next;
    logic signed [VEC_W-1:0] b_reg, b_next;
    logic [H_W-1:0]          ah_reg [3], ah_next [3];
    logic                    rej_reg, rej_next;

    logic [CW-1:0]           idx_reg, idx_next;
    logic [AW-1:0]           best_idx_reg, best_idx_next;
    logic signed [VEC_W-1:0] best_t_reg, best_t_next;
    logic                    found_reg, found_next;

    logic signed [POS_W-1:0] cen_reg [3], cen_next [3];
    logic [TAG_W-1:0]        btag_reg, btag_next;
    logic signed [PT_W-1:0]  p_reg [3], p_next [3];

    logic [K_W-1:0]          k_reg, k_next;
    logic [IT_W-1:0]         it_reg, it_next;

    logic                    m_valid_reg, m_valid_next;
    logic                    o_hit_reg, o_hit_next;
    logic [RAD_W-1:0]        o_dist_reg, o_dist_next;
    logic signed [POS_W-1:0] o_pt_reg [3], o_pt_next [3];
    logic signed [NRM_W-1:0] o_n_reg [3], o_n_next [3];
    logic [TAG_W-1:0]        o_tag_reg, o_tag_next;

    // ------------------------------------------------------------------
    // Shared datapath
    // ------------------------------------------------------------------
    logic signed [U_W-1:0]   opa;
    logic signed [VEC_W-1:0] opb;
    logic [RAD_W-1:0]        sq_op;
    logic signed [P_W-1:0]   mul_a;
    logic [SQ_W-1:0]         mul_s;

    assign mul_a = opa * opb;
    assign mul_s = SQ_W'(sq_op) * SQ_W'(sq_op);

    logic [1:0] kk, km;
    assign kk = (k_reg < K_W'(3)) ? k_reg[1:0] : 2'd0;
    assign km = (k_reg >= K_W'(1) && k_reg <= K_W'(3)) ? 2'(k_reg - K_W'(1)) : 2'd0;

    logic signed [SH_W-1:0]  shp;
    logic signed [H_W-1:0]   h_w;
    logic [H_W-1:0]          ah_w;
    assign shp  = SH_W'(prod_a_reg >>> FRAC_BITS);
    assign h_w  = H_W'(oc_reg[km]) - H_W'(shp);
    assign ah_w = h_w[H_W-1] ? H_W'(-h_w) : H_W'(h_w);

    // bit-serial floor square root, one result bit per cycle
    logic [REM_W+1:0]  rem_sh, trial;
    logic              sq_ge;
    logic [REM_W-1:0]  sq_rem_step;
    logic [ROOT_W-1:0] sq_root_step;
    assign rem_sh       = {sq_rem_reg, sq_x_reg[ACC_W-1 -: 2]};
    assign trial        = {2'b00, sq_root_reg, 2'b01};
    assign sq_ge        = rem_sh >= trial;
    assign sq_rem_step  = sq_ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
    assign sq_root_step = {sq_root_reg[ROOT_W-2:0], sq_ge};

    // restoring divide of (magnitude << FRAC_BITS) by the root
    logic            dv_ge;
    logic [ROOT_W:0] dv_r1;
    logic [Q_W-1:0]  dv_q_full;
    assign dv_ge     = dv_rem_reg >= {1'b0, sq_root_reg};
    assign dv_r1     = dv_ge ? dv_rem_reg - {1'b0, sq_root_reg} : dv_rem_reg;
    assign dv_q_full = {dv_q_reg[Q_W-2:0], dv_ge};

    logic signed [VEC_W-1:0] t_w;
    logic signed [PT_W-1:0]  p_w;
    logic signed [VEC_W-1:0] w_w;
    assign t_w = b_reg - $signed(VEC_W'(sq_root_reg));
    assign p_w = PT_W'(org_reg[km]) + PT_W'(shp);
    assign w_w = VEC_W'(PT_W'(cen_reg[km]) - p_w);

    logic [CMP_W-1:0] count_c;
    assign count_c = (CMP_W'(sphere_count_reg) > MAX_COUNT) ? MAX_COUNT
                                                             : CMP_W'(sphere_count_reg);

    // magnitudes and their maximum for the normaliser
    logic [VEC_W-1:0] abs_w [3];
    logic [VEC_W-1:0] max_w;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            abs_w[i] = vec_reg[i][VEC_W-1] ? VEC_W'(-vec_reg[i]) : VEC_W'(vec_reg[i]);
        end
        max_w = abs_w[0];
        if (abs_w[1] > max_w) begin
            max_w = abs_w[1];
        end
        if (abs_w[2] > max_w) begin
            max_w = abs_w[2];
        end
    end

    // result values
    logic                    facing;
    logic signed [U_W-1:0]   nf_w [3];
    logic signed [31:0]      n32_w [3];
    logic [RAD_W-1:0]        dist_w;
    logic signed [POS_W-1:0] pt_sat_w [3];
    logic signed [NRM_W-1:0] n_sat_w [3];
    always_comb begin
        facing = (dot_reg > DOT_W'(0));
        dist_w = (best_t_reg[VEC_W-2:RAD_W] != '0) ? {RAD_W{1'b1}} : best_t_reg[RAD_W-1:0];
        for (int i = 0; i < 3; i++) begin
            nf_w[i]  = facing ? U_W'(-nrm_reg[i]) : nrm_reg[i];
            n32_w[i] = 32'(nf_w[i]);
            if (n32_w[i] > NRM_MAX) begin
                n_sat_w[i] = NRM_W'(NRM_MAX);
            end else if (n32_w[i] < NRM_MIN) begin
                n_sat_w[i] = NRM_W'(NRM_MIN);
            end else begin
                n_sat_w[i] = n32_w[i][NRM_W-1:0];
            end
            if (p_reg[i] > PT_W'(32'sh7FFFFFFF)) begin
                pt_sat_w[i] = 32'sh7FFFFFFF;
            end else if (p_reg[i] < -PT_W'(33'sh080000000)) begin
                pt_sat_w[i] = 32'sh80000000;
            end else begin
                pt_sat_w[i] = p_reg[i][POS_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        org_next       = org_reg;
        u_next         = u_reg;
        nrm_next       = nrm_reg;
        vec_next       = vec_reg;
        na_next        = na_reg;
        sgn_next       = sgn_reg;
        nm_next        = nm_reg;
        norm_mode_next = norm_mode_reg;
        norm_ok_next   = norm_ok_reg;
        prod_a_next    = mul_a;
        prod_s_next    = mul_s;
        dot_next       = dot_reg;
        acc_next       = acc_reg;
        r2_next        = r2_reg;
        sq_x_next      = sq_x_reg;
        sq_rem_next    = sq_rem_reg;
        sq_root_next   = sq_root_reg;
        dv_rem_next    = dv_rem_reg;
        dv_q_next      = dv_q_reg;
        oc_next        = oc_reg;
        rad_next       = rad_reg;
        b_next         = b_reg;
        ah_next        = ah_reg;
        rej_next       = rej_reg;
        idx_next       = idx_reg;
        best_idx_next  = best_idx_reg;
        best_t_next    = best_t_reg;
        found_next     = found_reg;
        cen_next       = cen_reg;
        btag_next      = btag_reg;
        p_next         = p_reg;
        k_next         = k_reg;
        it_next        = it_reg;
        m_valid_next   = m_valid_reg & ~m_ready;
        o_hit_next     = o_hit_reg;
        o_dist_next    = o_dist_reg;
        o_pt_next      = o_pt_reg;
        o_n_next       = o_n_reg;
        o_tag_next     = o_tag_reg;

        opa       = u_reg[kk];
        opb       = '0;
        sq_op     = na_reg[kk][RAD_W-1:0];
        mem_we    = 1'b0;
        mem_waddr = AW'(s_slot);
        mem_wdata = '{cx: s_pos_x, cy: s_pos_y, cz: s_pos_z,
                      rad: s_sphere_radius, tag: s_material_tag};
        mem_re    = 1'b0;
        mem_raddr = idx_reg[AW-1:0];
        s_ready   = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_req_type == REQ_LOAD) begin
                        mem_we = ({4'd0, s_slot} < 8'(MAX_SPHERES)) || (MAX_SPHERES > 255);
                    end else begin
                        org_next[0]    = s_pos_x;
                        org_next[1]    = s_pos_y;
                        org_next[2]    = s_pos_z;
                        vec_next[0]    = VEC_W'(s_dir_x);
                        vec_next[1]    = VEC_W'(s_dir_y);
                        vec_next[2]    = VEC_W'(s_dir_z);
                        norm_mode_next = 1'b0;
                        state_next     = ST_NORM_INIT;
                    end
                end
            end

            ST_NORM_INIT: begin
                for (int i = 0; i < 3; i++) begin
                    na_next[i]  = abs_w[i];
                    sgn_next[i] = vec_reg[i][VEC_W-1];
                end
                nm_next    = max_w;
                state_next = ST_NORM_SHIFT;
            end

            // one bit a cycle until the largest magnitude sits in [2^30, 2^31)
            ST_NORM_SHIFT: begin
                if (nm_reg == '0) begin
                    norm_ok_next = 1'b0;
                    for (int i = 0; i < 3; i++) begin
                        nrm_next[i] = '0;
                    end
                    state_next = ST_NORM_END;
                end else if (nm_reg[VEC_W-1:31] != '0) begin
                    nm_next = nm_reg >> 1;
                    for (int i = 0; i < 3; i++) begin
                        na_next[i] = na_reg[i] >> 1;
                    end
                end else if (!nm_reg[30]) begin
                    nm_next = nm_reg << 1;
                    for (int i = 0; i < 3; i++) begin
                        na_next[i] = na_reg[i] << 1;
                    end
                end else begin
                    k_next     = '0;
                    state_next = ST_NORM_SQ;
                end
            end

            ST_NORM_SQ: begin
                sq_op  = na_reg[kk][RAD_W-1:0];
                k_next = k_reg + K_W'(1);
                if (k_reg == '0) begin
                    acc_next = '0;
                end else begin
                    acc_next = acc_reg + ACC_W'(prod_s_reg);
                end
                if (k_reg == K_W'(3)) begin
                    sq_x_next    = acc_reg + ACC_W'(prod_s_reg);
                    sq_rem_next  = '0;
                    sq_root_next = '0;
                    it_next      = '0;
                    state_next   = ST_NORM_SQRT;
                end
            end

            ST_NORM_SQRT: begin
                sq_x_next    = {sq_x_reg[ACC_W-3:0], 2'b00};
                sq_rem_next  = sq_rem_step;
                sq_root_next = sq_root_step;
                it_next      = it_reg + IT_W'(1);
                if (it_reg == SQRT_LAST) begin
                    k_next      = '0;
                    it_next     = '0;
                    dv_rem_next = {2'b00, na_reg[0][RAD_W-1:0]};
                    dv_q_next   = '0;
                    state_next  = ST_NORM_DIV;
                end
            end

            ST_NORM_DIV: begin
                dv_rem_next = {dv_r1[ROOT_W-1:0], 1'b0};
                dv_q_next   = dv_q_full;
                it_next     = it_reg + IT_W'(1);
                if (it_reg == DIV_LAST) begin
                    nrm_next[k_reg[1:0]] = sgn_reg[k_reg[1:0]]
                                         ? -$signed({1'b0, dv_q_full})
                                         :  $signed({1'b0, dv_q_full});
                    it_next = '0;
                    dv_q_next = '0;
                    if (k_reg == K_W'(2)) begin
                        norm_ok_next = 1'b1;
                        state_next   = ST_NORM_END;
                    end else begin
                        k_next      = k_reg + K_W'(1);
                        dv_rem_next = {2'b00, na_reg[2'(k_reg[1:0] + 2'd1)][RAD_W-1:0]};
                    end
                end
            end

            ST_NORM_END: begin
                k_next = '0;
                if (norm_mode_reg) begin
                    state_next = ST_ND;
                end else if (!norm_ok_reg) begin
                    found_next = 1'b0;
                    state_next = ST_FIN;
                end else begin
                    u_next     = nrm_reg;
                    found_next = 1'b0;
                    idx_next   = '0;
                    state_next = ST_RD;
                end
            end

            ST_RD: begin
                if (CMP_W'(idx_reg) == count_c) begin
                    state_next = found_reg ? ST_FRD : ST_FIN;
                end else begin
                    mem_re     = 1'b1;
                    state_next = ST_OC;
                end
            end

            ST_OC: begin
                oc_next[0] = OC_W'(rd_reg.cx) - OC_W'(org_reg[0]);
                oc_next[1] = OC_W'(rd_reg.cy) - OC_W'(org_reg[1]);
                oc_next[2] = OC_W'(rd_reg.cz) - OC_W'(org_reg[2]);
                rad_next   = rd_reg.rad;
                k_next     = '0;
                state_next = ST_DOT;
            end

            // products issue for k < 3 and are summed in the cycle after, from the product register
            ST_DOT: begin
                opa    = u_reg[kk];
                opb    = VEC_W'(oc_reg[kk]);
                k_next = k_reg + K_W'(1);
                if (k_reg == '0) begin
                    dot_next = '0;
                end else begin
                    dot_next = dot_reg + DOT_W'(prod_a_reg);
                end
                if (k_reg == K_W'(3)) begin
                    state_next = ST_B;
                end
            end

            ST_B: begin
                b_next     = VEC_W'(dot_reg >>> FRAC_BITS);
                rej_next   = 1'b0;
                k_next     = '0;
                state_next = ST_H;
            end

            ST_H: begin
                opa    = u_reg[kk];
                opb    = b_reg;
                k_next = k_reg + K_W'(1);
                if (k_reg != '0) begin
                    ah_next[km] = ah_w;
                    if (ah_w > H_W'(rad_reg)) begin
                        rej_next = 1'b1;
                    end
                end
                if (k_reg == K_W'(3)) begin
                    k_next     = '0;
                    state_next = ST_SQ;
                end
            end

            ST_SQ: begin
                sq_op  = (k_reg < K_W'(3)) ? ah_reg[kk][RAD_W-1:0] : rad_reg;
                k_next = k_reg + K_W'(1);
                if (k_reg == '0) begin
                    acc_next = '0;
                    if (rej_reg) begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = ST_RD;
                    end
                end else if (k_reg <= K_W'(3)) begin
                    acc_next = acc_reg + ACC_W'(prod_s_reg);
                end else begin
                    r2_next    = prod_s_reg;
                    state_next = ST_CMP;
                end
            end

            ST_CMP: begin
                if (acc_reg > ACC_W'(r2_reg)) begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = ST_RD;
                end else begin
                    sq_x_next    = ACC_W'(r2_reg) - acc_reg;
                    sq_rem_next  = '0;
                    sq_root_next = '0;
                    it_next      = '0;
                    state_next   = ST_TSQRT;
                end
            end

            ST_TSQRT: begin
                sq_x_next    = {sq_x_reg[ACC_W-3:0], 2'b00};
                sq_rem_next  = sq_rem_step;
                sq_root_next = sq_root_step;
                it_next      = it_reg + IT_W'(1);
                if (it_reg == SQRT_LAST) begin
                    state_next = ST_T;
                end
            end

            // strict compare: an equal distance keeps the lower entry
            ST_T: begin
                if (!t_w[VEC_W-1] && (!found_reg || t_w < best_t_reg)) begin
                    found_next    = 1'b1;
                    best_t_next   = t_w;
                    best_idx_next = idx_reg[AW-1:0];
                end
                idx_next   = idx_reg + CW'(1);
                state_next = ST_RD;
            end

            ST_FRD: begin
                mem_re     = 1'b1;
                mem_raddr  = best_idx_reg;
                state_next = ST_FC;
            end

            ST_FC: begin
                cen_next[0] = rd_reg.cx;
                cen_next[1] = rd_reg.cy;
                cen_next[2] = rd_reg.cz;
                btag_next   = rd_reg.tag;
                k_next      = '0;
                state_next  = ST_P;
            end

            ST_P: begin
                opa    = u_reg[kk];
                opb    = best_t_reg;
                k_next = k_reg + K_W'(1);
                if (k_reg != '0) begin
                    p_next[km]   = p_w;
                    vec_next[km] = w_w;
                end
                if (k_reg == K_W'(3)) begin
                    norm_mode_next = 1'b1;
                    state_next     = ST_NORM_INIT;
                end
            end

            ST_ND: begin
                opa    = u_reg[kk];
                opb    = VEC_W'(nrm_reg[kk]);
                k_next = k_reg + K_W'(1);
                if (k_reg == '0) begin
                    dot_next = '0;
                end else begin
                    dot_next = dot_reg + DOT_W'(prod_a_reg);
                end
                if (k_reg == K_W'(3)) begin
                    state_next = ST_FIN;
                end
            end

            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    o_hit_next   = found_reg;
                    if (found_reg) begin
                        o_dist_next = dist_w;
                        o_pt_next   = pt_sat_w;
                        o_n_next    = n_sat_w;
                        o_tag_next  = btag_reg;
                    end else begin
                        o_dist_next = '0;
                        o_tag_next  = '0;
                        for (int i = 0; i < 3; i++) begin
                            o_pt_next[i] = '0;
                            o_n_next[i]  = '0;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            m_valid_reg      <= 1'b0;
            sphere_count_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                sphere_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        org_reg       <= org_next;
        u_reg         <= u_next;
        nrm_reg       <= nrm_next;
        vec_reg       <= vec_next;
        na_reg        <= na_next;
        sgn_reg       <= sgn_next;
        nm_reg        <= nm_next;
        norm_mode_reg <= norm_mode_next;
        norm_ok_reg   <= norm_ok_next;
        prod_a_reg    <= prod_a_next;
        prod_s_reg    <= prod_s_next;
        dot_reg       <= dot_next;
        acc_reg       <= acc_next;
        r2_reg        <= r2_next;
        sq_x_reg      <= sq_x_next;
        sq_rem_reg    <= sq_rem_next;
        sq_root_reg   <= sq_root_next;
        dv_rem_reg    <= dv_rem_next;
        dv_q_reg      <= dv_q_next;
        oc_reg        <= oc_next;
        rad_reg       <= rad_next;
        b_reg         <= b_next;
        ah_reg        <= ah_next;
        rej_reg       <= rej_next;
        idx_reg       <= idx_next;
        best_idx_reg  <= best_idx_next;
        best_t_reg    <= best_t_next;
        found_reg     <= found_next;
        cen_reg       <= cen_next;
        btag_reg      <= btag_next;
        p_reg         <= p_next;
        k_reg         <= k_next;
        it_reg        <= it_next;
        o_hit_reg     <= o_hit_next;
        o_dist_reg    <= o_dist_next;
        o_pt_reg      <= o_pt_next;
        o_n_reg       <= o_n_next;
        o_tag_reg     <= o_tag_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_hit      = o_hit_reg;
    assign m_distance = o_dist_reg;
    assign m_point_x  = o_pt_reg[0];
    assign m_point_y  = o_pt_reg[1];
    assign m_point_z  = o_pt_reg[2];
    assign m_normal_x = o_n_reg[0];
    assign m_normal_y = o_n_reg[1];
    assign m_normal_z = o_n_reg[2];
    assign m_hit_tag  = o_tag_reg;

`ifndef SYNTH
    // the sphere walk never runs past the tested count
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD) |-> (CMP_W'(idx_reg) <= count_c))
        else $error("sphere index beyond count");

    // alignment leaves the largest magnitude in [2^30, 2^31)
    a_norm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_NORM_SQ) |-> (nm_reg[VEC_W-1:31] == '0 && nm_reg[30]))
        else $error("normaliser alignment out of range");

    // a rejected sphere never reaches the root
    a_rej_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TSQRT) |-> !rej_reg)
        else $error("rejected sphere entered root");

    // a kept hit distance is never negative
    a_best_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && found_reg) |-> !best_t_reg[VEC_W-1])
        else $error("negative hit distance kept");
`endif

endmodule
